### rtl/core/pctd_pkg.sv
package pctd_pkg;

   // Default sizes
   localparam int DEF_SYMBOL_COUNT = 256;
   localparam int DEF_MAX_CODE_LEN = 16;

   // Fixed field widths
   localparam int SYM_W  = 8;
   localparam int BITS_W = 16;
   localparam int LEN_W  = 5;

   // Opcodes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // One table entry as stored in memory
   typedef struct packed {
      logic [BITS_W-1:0] bits;
      logic [LEN_W-1:0]  len;
   } tbl_entry_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

### rtl/core/pctd_table.sv
module pctd_table import pctd_pkg::*; #(
   parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT,
   localparam int AW = $clog2(SYMBOL_COUNT)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  tbl_entry_type wr_entry,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output tbl_entry_type rd_entry
);

   tbl_entry_type               tbl_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0]     vld_ff;
   tbl_entry_type               rd_raw_ff;
   logic                        rd_vld_ff;

   // Entry storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_raw_ff <= tbl_mem[rd_addr];
      end
   end

   // Written flags; an unwritten entry reads as unused
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_vld_ff ? rd_raw_ff : '0;

endmodule

### rtl/core/prefix_code_table_decoder_top.sv
// Load transfer: written into the table at the accept edge, no result.
// Decode transfer: one registered table read per cycle in symbol order, stopping
// at the first hit. The next input is taken once a scan ends with no result, or
// once its result has moved into the output register; a held output stalls it.
// Synchronous reset clears the accumulator, control state and the table's
// per-entry written flags, so the table reads as all unused at once.
module prefix_code_table_decoder_top import pctd_pkg::*; #(
   parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT,
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [SYM_W-1:0]  req_entry_symbol,
   input  logic [BITS_W-1:0] req_entry_bits,
   input  logic [LEN_W-1:0]  req_entry_length,
   input  logic              req_stream_bit,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SYM_W-1:0]  rsp_decoded_symbol,
   output logic              rsp_no_match_error
);

   localparam int AW = $clog2(SYMBOL_COUNT);
   localparam int CW = $clog2(MAX_CODE_LEN + 1);
   localparam int W  = (MAX_CODE_LEN > BITS_W) ? MAX_CODE_LEN : BITS_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(SYMBOL_COUNT - 1);
   localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_CODE_LEN);

   state_type               state_ff, state_in;
   logic [MAX_CODE_LEN-1:0] pend_bits_ff, pend_bits_in;
   logic [CW-1:0]           pend_cnt_ff, pend_cnt_in;
   logic [AW-1:0]           scan_addr_ff, scan_addr_in;
   logic                    issued_all_ff, issued_all_in;
   logic                    chk_ff, chk_in;
   logic [AW-1:0]           chk_idx_ff;
   logic [SYM_W-1:0]        res_sym_ff, res_sym_in;
   logic                    res_err_ff, res_err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]        rsp_sym_ff;
   logic                    rsp_err_ff;

   logic                    req_xfer;
   logic                    wr_en;
   logic                    issue;
   tbl_entry_type           wr_entry;
   tbl_entry_type           rd_entry;
   logic [W-1:0]            len_mask;
   logic                    hit;
   logic                    out_free;

   assign req_xfer = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Table write on load transfers with a symbol in range
   assign wr_en = req_xfer && (req_opcode == OP_LOAD) &&
                  ({1'b0, req_entry_symbol} < 9'(SYMBOL_COUNT));
   assign wr_entry.bits = req_entry_bits;
   assign wr_entry.len  = req_entry_length;
   assign issue = (state_ff == ST_SCAN) && !issued_all_ff;

   pctd_table #(
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (req_entry_symbol[AW-1:0]),
      .wr_entry (wr_entry),
      .rd_en    (issue),
      .rd_addr  (scan_addr_ff),
      .rd_entry (rd_entry)
   );

   // Compare the entry read last cycle against the accumulator
   always_comb begin
      for (int i = 0; i < W; i++) begin
         len_mask[i] = (6'(i) < {1'b0, rd_entry.len});
      end
   end

   assign hit = chk_ff && (rd_entry.len != '0) &&
                ({1'b0, rd_entry.len} == 6'(pend_cnt_ff)) &&
                ((W'(rd_entry.bits) & len_mask) == W'(pend_bits_ff));

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      pend_bits_in  = pend_bits_ff;
      pend_cnt_in   = pend_cnt_ff;
      scan_addr_in  = scan_addr_ff;
      issued_all_in = issued_all_ff;
      chk_in        = 1'b0;
      res_sym_in    = res_sym_ff;
      res_err_in    = res_err_ff;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_xfer && (req_opcode == OP_DECODE)) begin
               pend_bits_in  = {pend_bits_ff[MAX_CODE_LEN-2:0], req_stream_bit};
               pend_cnt_in   = pend_cnt_ff + 1'b1;
               scan_addr_in  = '0;
               issued_all_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            chk_in = issue;
            if (issue) begin
               if (scan_addr_ff == LAST_ADDR) begin
                  issued_all_in = 1'b1;
               end else begin
                  scan_addr_in = scan_addr_ff + 1'b1;
               end
            end
            if (hit) begin
               res_sym_in   = SYM_W'(chk_idx_ff);
               res_err_in   = 1'b0;
               pend_bits_in = '0;
               pend_cnt_in  = '0;
               chk_in       = 1'b0;
               state_in     = ST_EMIT;
            end else if (chk_ff && (chk_idx_ff == LAST_ADDR)) begin
               if (pend_cnt_ff == MAX_CNT) begin
                  res_sym_in   = '0;
                  res_err_in   = 1'b1;
                  pend_bits_in = '0;
                  pend_cnt_in  = '0;
                  state_in     = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if ((state_ff == ST_EMIT) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_bits_ff  <= '0;
         pend_cnt_ff   <= '0;
         issued_all_ff <= 1'b0;
         chk_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_bits_ff  <= pend_bits_in;
         pend_cnt_ff   <= pend_cnt_in;
         issued_all_ff <= issued_all_in;
         chk_ff        <= chk_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      chk_idx_ff   <= scan_addr_ff;
      res_sym_ff   <= res_sym_in;
      res_err_ff   <= res_err_in;
      if ((state_ff == ST_EMIT) && out_free) begin
         rsp_sym_ff <= res_sym_ff;
         rsp_err_ff <= res_err_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_decoded_symbol = rsp_sym_ff;
   assign rsp_no_match_error = rsp_err_ff;

`ifndef ASSERT_OFF
   // Accumulator never runs past the longest code
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff <= MAX_CNT)
      else $error("accumulator count above maximum code length");

   // An error result always carries symbol zero
   a_err_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_sym_ff == '0)
      else $error("error result with nonzero symbol");

   // Compare slot is only live during a scan
   a_chk_scan: assert property (@(posedge clock) disable iff (reset)
      chk_ff |-> state_ff == ST_SCAN)
      else $error("table compare outside of scan");

   // Accumulator is cleared whenever a result is pending emission
   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> pend_cnt_ff == '0)
      else $error("accumulator not cleared with result");

   // Each emission loads the output register
   a_emit_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && out_free |=> rsp_valid_ff)
      else $error("result lost on emission");
`endif

endmodule
